FILE: hdl/sli_pkg.sv
// Shared constants and codes for the segment/line intersection block.
package sli_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int PORT_W          = 32;   // width of coordinate ports
  localparam int QUOT_BITS       = 62;   // quotient magnitude capped at 2^62
  localparam int THR_W           = 63;
  localparam int TOL_W           = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_ADDR_W      = 4;

  localparam logic [THR_W-1:0] THR_RESET = 63'd4295;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // register index, taken from address bit 3 (8-byte spacing)
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  localparam logic [1:0] MODE_SEG_SEG  = 2'd0;
  localparam logic [1:0] MODE_SEG_LINE = 2'd1;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

endpackage

FILE: hdl/sli_front.sv
// Front end: differences, cross products, denominator, magnitudes, parallel test.
module sli_front #(
  parameter int COORD_WIDTH = sli_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = sli_pkg::DEF_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  logic [1:0]                             in_mode,
  input  logic signed [COORD_WIDTH-1:0]          in_a1x,
  input  logic signed [COORD_WIDTH-1:0]          in_a1y,
  input  logic signed [COORD_WIDTH-1:0]          in_a2x,
  input  logic signed [COORD_WIDTH-1:0]          in_a2y,
  input  logic signed [COORD_WIDTH-1:0]          in_b1x,
  input  logic signed [COORD_WIDTH-1:0]          in_b1y,
  input  logic signed [COORD_WIDTH-1:0]          in_b2x,
  input  logic signed [COORD_WIDTH-1:0]          in_b2y,
  input  logic [sli_pkg::THR_W-1:0]              thr,
  output logic                                   out_vld,
  output logic [2*(COORD_WIDTH+1)+FRAC_BITS:0]   out_num_r,
  output logic [2*(COORD_WIDTH+1)+FRAC_BITS:0]   out_num_s,
  output logic [2*(COORD_WIDTH+1):0]             out_den,
  output logic                                   out_neg_s,
  output logic [4+4*COORD_WIDTH+1:0]             out_side
);
  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int MW  = PW + 1;
  localparam int NW  = MW + FRAC_BITS;
  localparam int SW  = 4 + 2 * DW + 2 * CW;

  // stage 1: differences
  logic                 v1_r;
  logic [1:0]           mode1_r;
  logic signed [DW-1:0] dax_r, day_r, dbx_r, dby_r, ex_r, ey_r;
  logic signed [CW-1:0] a1x1_r, a1y1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    mode1_r <= in_mode;
    dax_r   <= DW'(in_a2x) - DW'(in_a1x);
    day_r   <= DW'(in_a2y) - DW'(in_a1y);
    dbx_r   <= DW'(in_b2x) - DW'(in_b1x);
    dby_r   <= DW'(in_b2y) - DW'(in_b1y);
    ex_r    <= DW'(in_a1x) - DW'(in_b1x);
    ey_r    <= DW'(in_a1y) - DW'(in_b1y);
    a1x1_r  <= in_a1x;
    a1y1_r  <= in_a1y;
  end

  // stage 2: six products
  logic                 v2_r;
  logic [1:0]           mode2_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [DW-1:0] dax2_r, day2_r;
  logic signed [CW-1:0] a1x2_r, a1y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    p0_r    <= PW'(dax_r) * PW'(dby_r);
    p1_r    <= PW'(day_r) * PW'(dbx_r);
    p2_r    <= PW'(ey_r) * PW'(dbx_r);
    p3_r    <= PW'(ex_r) * PW'(dby_r);
    p4_r    <= PW'(ey_r) * PW'(dax_r);
    p5_r    <= PW'(ex_r) * PW'(day_r);
    mode2_r <= mode1_r;
    dax2_r  <= dax_r;
    day2_r  <= day_r;
    a1x2_r  <= a1x1_r;
    a1y2_r  <= a1y1_r;
  end

  // stage 3: denominator and numerators
  logic                 v3_r;
  logic [1:0]           mode3_r;
  logic signed [MW-1:0] den_r, nr_r, ns_r;
  logic signed [DW-1:0] dax3_r, day3_r;
  logic signed [CW-1:0] a1x3_r, a1y3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    den_r   <= MW'(p0_r) - MW'(p1_r);
    nr_r    <= MW'(p2_r) - MW'(p3_r);
    ns_r    <= MW'(p4_r) - MW'(p5_r);
    mode3_r <= mode2_r;
    dax3_r  <= dax2_r;
    day3_r  <= day2_r;
    a1x3_r  <= a1x2_r;
    a1y3_r  <= a1y2_r;
  end

  // stage 4: magnitudes, signs, parallel test
  logic [MW-1:0] dmag, rmag, smag;
  logic          par, neg_r, neg_s;

  assign dmag  = den_r[MW-1] ? MW'(-den_r) : MW'(den_r);
  assign rmag  = nr_r[MW-1]  ? MW'(-nr_r)  : MW'(nr_r);
  assign smag  = ns_r[MW-1]  ? MW'(-ns_r)  : MW'(ns_r);
  assign par   = (dmag == '0) || (dmag < MW'(thr));
  assign neg_r = nr_r[MW-1] ^ den_r[MW-1];
  assign neg_s = ns_r[MW-1] ^ den_r[MW-1];

  logic                 v4_r;
  logic [NW-1:0]        num_r_r, num_s_r;
  logic [MW-1:0]        den4_r;
  logic                 neg_s_r;
  logic [SW-1:0]        side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    num_r_r <= NW'(rmag) << FRAC_BITS;
    num_s_r <= NW'(smag) << FRAC_BITS;
    den4_r  <= dmag;
    neg_s_r <= neg_s;
    side_r  <= {par, mode3_r, neg_r, dax3_r, day3_r, a1x3_r, a1y3_r};
  end

  assign out_vld   = v4_r;
  assign out_num_r = num_r_r;
  assign out_num_s = num_s_r;
  assign out_den   = den4_r;
  assign out_neg_s = neg_s_r;
  assign out_side  = side_r;

endmodule

FILE: hdl/sli_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow cap.
module sli_div #(
  parameter int MW = 67,
  parameter int NW = 83,
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [NW-1:0]                 in_num,
  input  logic [MW-1:0]                 in_den,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_vld,
  output logic [sli_pkg::QUOT_BITS-1:0] out_quo,
  output logic                          out_ovf,
  output logic [SW-1:0]                 out_side
);
  localparam int QB = sli_pkg::QUOT_BITS;
  localparam int RW = MW + QB;

  logic          vld_r  [0:QB];
  logic [RW-1:0] rem_r  [0:QB];
  logic [MW-1:0] den_r  [0:QB];
  logic [QB-1:0] quo_r  [0:QB];
  logic          ovf_r  [0:QB];
  logic [SW-1:0] side_r [0:QB];

  // entry stage: quotient of 2^QB or more is capped
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= RW'(in_num);
    den_r[0]  <= in_den;
    quo_r[0]  <= '0;
    ovf_r[0]  <= RW'(in_num) >= (RW'(in_den) << QB);
    side_r[0] <= in_side;
  end

  for (genvar j = 1; j <= QB; j++) begin : g_stage
    localparam int SH = QB - j;
    logic [RW-1:0] dsh;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [QB-1:0] quo_nxt;

    assign dsh     = RW'(den_r[j-1]) << SH;
    assign ge      = rem_r[j-1] >= dsh;
    assign rem_nxt = ge ? rem_r[j-1] - dsh : rem_r[j-1];
    assign quo_nxt = quo_r[j-1] | (QB'(ge) << SH);

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[j] <= 1'b0;
      else        vld_r[j] <= vld_r[j-1];
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= rem_nxt;
      den_r[j]  <= den_r[j-1];
      quo_r[j]  <= quo_nxt;
      ovf_r[j]  <= ovf_r[j-1];
      side_r[j] <= side_r[j-1];
    end
  end

  assign out_vld  = vld_r[QB];
  assign out_quo  = quo_r[QB];
  assign out_ovf  = ovf_r[QB];
  assign out_side = side_r[QB];

endmodule

FILE: hdl/sli_back.sv
// Back end: signed parameters, range checks, status, intersection point.
module sli_back #(
  parameter int COORD_WIDTH = sli_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = sli_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic [sli_pkg::QUOT_BITS-1:0]       in_quo_r,
  input  logic                                in_ovf_r,
  input  logic [sli_pkg::QUOT_BITS-1:0]       in_quo_s,
  input  logic                                in_ovf_s,
  input  logic                                in_neg_s,
  input  logic [4+4*COORD_WIDTH+1:0]          in_side,
  input  logic [sli_pkg::TOL_W-1:0]           tol,
  output logic                                out_strobe,
  output sli_pkg::status_t                    out_status,
  output logic [sli_pkg::PORT_W-1:0]          out_param_r,
  output logic [sli_pkg::PORT_W-1:0]          out_cross_x,
  output logic [sli_pkg::PORT_W-1:0]          out_cross_y
);
  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int QB = sli_pkg::QUOT_BITS;
  localparam int XW = CW + DW;       // point product width
  localparam int SUMW = XW + 1;
  localparam int PO = sli_pkg::PORT_W;
  localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -(64'sd1 <<< (CW - 1));
  localparam logic signed [SUMW-1:0] SMAX = SUMW'(CMAX);
  localparam logic signed [SUMW-1:0] SMIN = SUMW'(CMIN);

  logic                 par, neg_r;
  logic [1:0]           mode;
  logic signed [DW-1:0] dax, day;
  logic signed [CW-1:0] a1x, a1y;

  assign {par, mode, neg_r, dax, day, a1x, a1y} = in_side;

  // stage B1: sign, range checks, saturated r
  logic [QB:0]          rmag, smag;
  logic signed [63:0]   rv, sv, tv;
  logic                 bad_r, bad_s, checked;
  logic signed [CW-1:0] rs;
  sli_pkg::status_t     st;

  assign rmag  = in_ovf_r ? ((QB+1)'(1) << QB) : (QB+1)'(in_quo_r);
  assign smag  = in_ovf_s ? ((QB+1)'(1) << QB) : (QB+1)'(in_quo_s);
  assign rv    = neg_r    ? -$signed(64'(rmag)) : $signed(64'(rmag));
  assign sv    = in_neg_s ? -$signed(64'(smag)) : $signed(64'(smag));
  assign tv    = $signed(64'(tol));
  assign bad_r = (rv < -tv) || (rv > ONE + tv);
  assign bad_s = (sv < -tv) || (sv > ONE + tv);
  assign checked = (mode == sli_pkg::MODE_SEG_SEG) || (mode == sli_pkg::MODE_SEG_LINE);
  assign rs    = (rv > CMAX) ? CW'(CMAX) : ((rv < CMIN) ? CW'(CMIN) : CW'(rv));

  always_comb begin
    if (par)
      st = sli_pkg::ST_PARALLEL;
    else if (checked && (bad_r || ((mode == sli_pkg::MODE_SEG_SEG) && bad_s)))
      st = sli_pkg::ST_OUTSIDE;
    else
      st = sli_pkg::ST_HIT;
  end

  logic                 v1_r;
  sli_pkg::status_t     st1_r;
  logic signed [CW-1:0] rs1_r, a1x1_r, a1y1_r;
  logic signed [DW-1:0] dax1_r, day1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    st1_r  <= st;
    rs1_r  <= rs;
    dax1_r <= dax;
    day1_r <= day;
    a1x1_r <= a1x;
    a1y1_r <= a1y;
  end

  // stage B2: r times direction of A
  logic                 v2_r;
  sli_pkg::status_t     st2_r;
  logic signed [CW-1:0] rs2_r, a1x2_r, a1y2_r;
  logic signed [XW-1:0] prx_r, pry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    prx_r  <= XW'(rs1_r) * XW'(dax1_r);
    pry_r  <= XW'(rs1_r) * XW'(day1_r);
    st2_r  <= st1_r;
    rs2_r  <= rs1_r;
    a1x2_r <= a1x1_r;
    a1y2_r <= a1y1_r;
  end

  // stage B3: floor shift, add origin, saturate
  logic signed [SUMW-1:0] sx, sy;
  logic signed [CW-1:0]   cx, cy;

  assign sx = SUMW'(prx_r >>> FRAC_BITS) + SUMW'(a1x2_r);
  assign sy = SUMW'(pry_r >>> FRAC_BITS) + SUMW'(a1y2_r);
  assign cx = (sx > SMAX) ? CW'(SMAX) : ((sx < SMIN) ? CW'(SMIN) : CW'(sx));
  assign cy = (sy > SMAX) ? CW'(SMAX) : ((sy < SMIN) ? CW'(SMIN) : CW'(sy));

  logic             v3_r;
  sli_pkg::status_t st3_r;
  logic [PO-1:0]    pr3_r, cx3_r, cy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    st3_r <= st2_r;
    pr3_r <= (st2_r == sli_pkg::ST_PARALLEL) ? '0 : PO'(rs2_r);
    cx3_r <= (st2_r == sli_pkg::ST_HIT) ? PO'(cx) : '0;
    cy3_r <= (st2_r == sli_pkg::ST_HIT) ? PO'(cy) : '0;
  end

  assign out_strobe  = v3_r;
  assign out_status  = st3_r;
  assign out_param_r = pr3_r;
  assign out_cross_x = cx3_r;
  assign out_cross_y = cy3_r;

endmodule

FILE: hdl/segment_line_intersection.sv
// Top level: segment/line intersection pipeline with APB configuration registers.
//
// Usage: an item (mode and two point pairs, signed fixed point) is a transfer
// at the clock edge where start is high and busy is low. busy is never raised:
// one item may enter on every cycle.
// Each item produces exactly one result, shown on out_* for one cycle with
// out_strobe high; the receiver must take it then and cannot stall the block.
// Pipeline: 4 front-end stages (differences, products, subtracts, magnitudes),
// 63 divider stages (cap check plus one quotient bit per stage for 62 bits),
// and 3 back-end stages (range check, point multiply, shift/add/saturate).
// Throughput: one item per cycle, set by the fully pipelined divider.
// Reset (rst_n low, synchronous) clears every stage valid bit, so nothing in
// flight comes out, and loads threshold 4295 and tolerance 1.
// Config: threshold at byte address 0, tolerance at 8 (address bit 3 selects),
// 64-bit data, always ready. Write only while no item is in flight.
module segment_line_intersection #(
  parameter int COORD_WIDTH = sli_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = sli_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_req_type,
  input  logic [sli_pkg::PORT_W-1:0]      in_a1_x,
  input  logic [sli_pkg::PORT_W-1:0]      in_a1_y,
  input  logic [sli_pkg::PORT_W-1:0]      in_a2_x,
  input  logic [sli_pkg::PORT_W-1:0]      in_a2_y,
  input  logic [sli_pkg::PORT_W-1:0]      in_b1_x,
  input  logic [sli_pkg::PORT_W-1:0]      in_b1_y,
  input  logic [sli_pkg::PORT_W-1:0]      in_b2_x,
  input  logic [sli_pkg::PORT_W-1:0]      in_b2_y,
  output logic                            out_strobe,
  output logic [1:0]                      out_status,
  output logic [sli_pkg::PORT_W-1:0]      out_param_r,
  output logic [sli_pkg::PORT_W-1:0]      out_cross_x,
  output logic [sli_pkg::PORT_W-1:0]      out_cross_y,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sli_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sli_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sli_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int MW = 2 * DW + 1;          // denominator magnitude
  localparam int NW = MW + FRAC_BITS;      // shifted numerator magnitude
  localparam int SW = 4 + 2 * DW + 2 * CW; // sideband riding with the quotient
  localparam int QB = sli_pkg::QUOT_BITS;

  // ---------------- configuration registers ----------------
  logic [sli_pkg::THR_W-1:0] thr_r;
  logic [sli_pkg::TOL_W-1:0] tol_r;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= sli_pkg::THR_RESET;
      tol_r <= sli_pkg::TOL_RESET;
    end else if (cfg_wr) begin
      if (paddr[3] == sli_pkg::REG_THRESHOLD) thr_r <= pwdata[sli_pkg::THR_W-1:0];
      else                                     tol_r <= pwdata[sli_pkg::TOL_W-1:0];
    end
  end

  assign prdata = (paddr[3] == sli_pkg::REG_TOLERANCE)
                ? sli_pkg::CFG_DATA_W'(tol_r) : sli_pkg::CFG_DATA_W'(thr_r);

  // ---------------- input transfer ----------------
  logic in_xfer;

  assign busy    = 1'b0;             // fully pipelined, never refuses an item
  assign in_xfer = start && !busy;

  // ---------------- front end ----------------
  logic          f_vld, f_neg_s;
  logic [NW-1:0] f_num_r, f_num_s;
  logic [MW-1:0] f_den;
  logic [SW-1:0] f_side;

  sli_front #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_xfer),
    .in_mode   (in_req_type),
    .in_a1x    ($signed(in_a1_x[CW-1:0])),
    .in_a1y    ($signed(in_a1_y[CW-1:0])),
    .in_a2x    ($signed(in_a2_x[CW-1:0])),
    .in_a2y    ($signed(in_a2_y[CW-1:0])),
    .in_b1x    ($signed(in_b1_x[CW-1:0])),
    .in_b1y    ($signed(in_b1_y[CW-1:0])),
    .in_b2x    ($signed(in_b2_x[CW-1:0])),
    .in_b2y    ($signed(in_b2_y[CW-1:0])),
    .thr       (thr_r),
    .out_vld   (f_vld),
    .out_num_r (f_num_r),
    .out_num_s (f_num_s),
    .out_den   (f_den),
    .out_neg_s (f_neg_s),
    .out_side  (f_side)
  );

  // ---------------- two dividers in lockstep: r and s ----------------
  logic          dr_vld, dr_ovf, ds_vld, ds_ovf, ds_neg;
  logic [QB-1:0] dr_quo, ds_quo;
  logic [SW-1:0] dr_side;

  sli_div #(.MW(MW), .NW(NW), .SW(SW)) u_div_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld),
    .in_num   (f_num_r),
    .in_den   (f_den),
    .in_side  (f_side),
    .out_vld  (dr_vld),
    .out_quo  (dr_quo),
    .out_ovf  (dr_ovf),
    .out_side (dr_side)
  );

  sli_div #(.MW(MW), .NW(NW), .SW(1)) u_div_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld),
    .in_num   (f_num_s),
    .in_den   (f_den),
    .in_side  (f_neg_s),
    .out_vld  (ds_vld),
    .out_quo  (ds_quo),
    .out_ovf  (ds_ovf),
    .out_side (ds_neg)
  );

  // ---------------- back end ----------------
  sli_pkg::status_t b_status;

  sli_back #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (dr_vld),
    .in_quo_r    (dr_quo),
    .in_ovf_r    (dr_ovf),
    .in_quo_s    (ds_quo),
    .in_ovf_s    (ds_ovf),
    .in_neg_s    (ds_neg),
    .in_side     (dr_side),
    .tol         (tol_r),
    .out_strobe  (out_strobe),
    .out_status  (b_status),
    .out_param_r (out_param_r),
    .out_cross_x (out_cross_x),
    .out_cross_y (out_cross_y)
  );

  assign out_status = b_status;

  // ---------------- assertions ----------------
  // both dividers must stay in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dr_vld == ds_vld)
    else $error("divider valid bits diverged");

  // a parallel result carries no parameter and no point
  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (b_status == sli_pkg::ST_PARALLEL) |->
      (out_param_r == '0) && (out_cross_x == '0) && (out_cross_y == '0))
    else $error("parallel result with nonzero fields");

  // no point unless an intersection was found
  a_miss_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (b_status != sli_pkg::ST_HIT) |->
      (out_cross_x == '0) && (out_cross_y == '0))
    else $error("point reported without intersection");

  // threshold write lands in the register
  a_thr_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (paddr[3] == sli_pkg::REG_THRESHOLD) |=>
      thr_r == $past(pwdata[sli_pkg::THR_W-1:0]))
    else $error("threshold write lost");

endmodule
